// ===== sv/pcct_pkg.sv =====
// ----------------------------------------------------------------------------
// pcct_pkg
// Shared types, constants and code tables of the prefix code transcoder.
// ----------------------------------------------------------------------------
package pcct_pkg;

	// Field widths and group geometry
	localparam int CHAR_W      = 8;
	localparam int GROUP_BITS  = 5;
	localparam int ACC_W       = 12;   // widest pending word: 4 left over + 8 new
	localparam int CNT_W       = 4;    // holds a bit count of 0..12
	localparam int REM_W       = 4;    // bits left over between characters
	localparam int REMCNT_W    = 3;    // count of left-over bits, 0..4
	localparam int LEN_W       = 4;    // code length 3..8
	localparam int CODE_W      = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

	// One input beat
	typedef struct packed {
		logic [CHAR_W-1:0] in_char;
		logic              char_valid;
		logic              end_of_line;
	} in_item_t;

	// One result beat
	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              last;
	} out_item_t;

	// Work handed from the front end to the back end
	typedef struct packed {
		logic [ACC_W-1:0] word;   // pending bits, right-aligned
		logic [CNT_W-1:0] cnt;    // number of pending bits
		logic             eol;    // flush and close the line after the groups
	} job_t;

	// Front to queue push request
	typedef struct packed {
		logic valid;
		job_t job;
	} push_req_t;

	// Prefix code of one character
	typedef struct packed {
		logic              hit;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} code_ent_t;

	function automatic code_ent_t char_lookup(input logic [CHAR_W-1:0] ch);
		code_ent_t e;
		e.hit  = 1'b1;
		e.code = '0;
		e.len  = '0;
		case (ch)
			"A":  begin e.code = 8'h25; e.len = 4'd6; end
			"B":  begin e.code = 8'h9A; e.len = 4'd8; end
			"C":  begin e.code = 8'h05; e.len = 4'd4; end
			"D":  begin e.code = 8'h01; e.len = 4'd4; end
			"E":  begin e.code = 8'h06; e.len = 4'd3; end
			"F":  begin e.code = 8'h09; e.len = 4'd5; end
			"G":  begin e.code = 8'h9B; e.len = 4'd8; end
			"H":  begin e.code = 8'h10; e.len = 4'd6; end
			"I":  begin e.code = 8'h07; e.len = 4'd4; end
			"J":  begin e.code = 8'h98; e.len = 4'd8; end
			"K":  begin e.code = 8'h06; e.len = 4'd4; end
			"L":  begin e.code = 8'h04; e.len = 4'd5; end
			"M":  begin e.code = 8'h99; e.len = 4'd8; end
			"N":  begin e.code = 8'h9E; e.len = 4'd8; end
			"O":  begin e.code = 8'h05; e.len = 4'd5; end
			"P":  begin e.code = 8'h07; e.len = 4'd3; end
			"Q":  begin e.code = 8'h9F; e.len = 4'd8; end
			"R":  begin e.code = 8'h08; e.len = 4'd4; end
			"S":  begin e.code = 8'h06; e.len = 4'd5; end
			"T":  begin e.code = 8'h07; e.len = 4'd5; end
			"U":  begin e.code = 8'h9C; e.len = 4'd8; end
			"V":  begin e.code = 8'h9D; e.len = 4'd8; end
			"W":  begin e.code = 8'h02; e.len = 4'd6; end
			"X":  begin e.code = 8'h92; e.len = 4'd8; end
			"Y":  begin e.code = 8'h93; e.len = 4'd8; end
			"Z":  begin e.code = 8'h90; e.len = 4'd8; end
			" ":  begin e.code = 8'h05; e.len = 4'd3; end
			".":  begin e.code = 8'h11; e.len = 4'd6; end
			",":  begin e.code = 8'h03; e.len = 4'd6; end
			"-":  begin e.code = 8'h91; e.len = 4'd8; end
			8'd39: begin e.code = 8'h00; e.len = 4'd6; end  // apostrophe
			"?":  begin e.code = 8'h01; e.len = 4'd6; end
			default: begin e.hit = 1'b0; end
		endcase
		return e;
	endfunction

	// 5-bit group value to character
	function automatic logic [CHAR_W-1:0] group_char(input logic [GROUP_BITS-1:0] g);
		logic [CHAR_W-1:0] c;
		case (g)
			5'd26:   c = " ";
			5'd27:   c = ".";
			5'd28:   c = ",";
			5'd29:   c = "-";
			5'd30:   c = 8'd39;
			5'd31:   c = "?";
			default: c = 8'(8'd65 + {3'd0, g});
		endcase
		return c;
	endfunction

endpackage

// ===== sv/prefix_code_char_transcoder_core.sv =====
// Prefix code character transcoder. Each input beat on chr carries one
// character; table characters are turned into their 3 to 8 bit prefix code
// and every full 5-bit group is sent on grp as a character, with a padded
// remainder group and a newline beat (last set) at end of line. Intake takes
// one beat per cycle while the four-entry job queue has room; the output
// register sends one beat per cycle while grp_stall is low, and an item
// yields 0 to 4 beats, so the sustained rate is set by the output port. An
// accepted input passes through the job queue and the back end's job
// registers before its first beat is registered for output.
// ----------------------------------------------------------------------------
// prefix_code_char_transcoder_core
// Top level: front end, job queue and back end.
// ----------------------------------------------------------------------------
module prefix_code_char_transcoder_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 chr_valid,
	output logic                 chr_stall,
	input  pcct_pkg::in_item_t   chr,
	output logic                 grp_valid,
	input  logic                 grp_stall,
	output pcct_pkg::out_item_t  grp
);

	pcct_pkg::push_req_t push;
	pcct_pkg::job_t      q_head;
	logic                q_full;
	logic                q_nonempty;
	logic                q_pop;

	pcct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr       (chr),
		.q_full    (q_full),
		.push      (push)
	);

	pcct_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	pcct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.grp_valid  (grp_valid),
		.grp_stall  (grp_stall),
		.grp        (grp)
	);

endmodule

// ===== sv/pcct_front.sv =====
// ----------------------------------------------------------------------------
// pcct_front
// Intake: looks up each character's prefix code, merges it with the bits
// left over from earlier characters and hands off work that yields beats.
// ----------------------------------------------------------------------------
module pcct_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                chr_valid,
	output logic                chr_stall,
	input  pcct_pkg::in_item_t  chr,
	input  logic                q_full,
	output pcct_pkg::push_req_t push
);

	logic [pcct_pkg::REM_W-1:0]    acc_q;
	logic [pcct_pkg::REMCNT_W-1:0] cnt_q;

	pcct_pkg::code_ent_t         ent;
	logic                        use_code;
	logic [pcct_pkg::ACC_W-1:0]  word;
	logic [pcct_pkg::CNT_W-1:0]  tcnt;
	logic [pcct_pkg::CNT_W-1:0]  rem_cnt;
	logic [pcct_pkg::REM_W:0]    rem_mask;
	logic                        accept;

	// Code lookup and merge with left-over bits
	always_comb begin
		ent      = pcct_pkg::char_lookup(chr.in_char);
		use_code = chr.char_valid && ent.hit;
		if (use_code) begin
			word = ({{(pcct_pkg::ACC_W-pcct_pkg::REM_W){1'b0}}, acc_q} << ent.len)
				| {{(pcct_pkg::ACC_W-pcct_pkg::CODE_W){1'b0}}, ent.code};
			tcnt = {1'b0, cnt_q} + ent.len;
		end else begin
			word = {{(pcct_pkg::ACC_W-pcct_pkg::REM_W){1'b0}}, acc_q};
			tcnt = {1'b0, cnt_q};
		end
	end

	// Bits left once every full group has been taken out
	always_comb begin
		if (tcnt >= 4'd10) begin
			rem_cnt = tcnt - 4'd10;
		end else if (tcnt >= 4'd5) begin
			rem_cnt = tcnt - 4'd5;
		end else begin
			rem_cnt = tcnt;
		end
		rem_mask = 5'(5'd1 << rem_cnt) - 5'd1;
	end

	assign chr_stall = q_full;
	assign accept    = chr_valid && !q_full;

	// Only beats that produce output go to the back end
	always_comb begin
		push.valid    = accept && (tcnt >= 4'd5 || chr.end_of_line);
		push.job.word = word;
		push.job.cnt  = tcnt;
		push.job.eol  = chr.end_of_line;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (chr.end_of_line) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= word[pcct_pkg::REM_W-1:0] & rem_mask[pcct_pkg::REM_W-1:0];
				cnt_q <= rem_cnt[pcct_pkg::REMCNT_W-1:0];
			end
		end
	end

endmodule

// ===== sv/pcct_queue.sv =====
// ----------------------------------------------------------------------------
// pcct_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pcct_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  pcct_pkg::push_req_t push,
	output logic                full,
	input  logic                pop,
	output logic                nonempty,
	output pcct_pkg::job_t      head
);

	pcct_pkg::job_t               mem_q [pcct_pkg::QUEUE_DEPTH];
	logic [pcct_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [pcct_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [pcct_pkg::QCNT_W-1:0]  count_q;
	logic                         do_push;
	logic                         do_pop;

	assign full     = (count_q == pcct_pkg::QCNT_W'(pcct_pkg::QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign do_push  = push.valid && !full;
	assign do_pop   = pop && nonempty;
	assign head     = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/pcct_back.sv =====
// ----------------------------------------------------------------------------
// pcct_back
// Emit side: walks a job one beat a cycle unless the output stalls, full
// groups first, then the zero-padded remainder and the newline at end of line.
// ----------------------------------------------------------------------------
module pcct_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_nonempty,
	input  pcct_pkg::job_t       q_head,
	output logic                 q_pop,
	output logic                 grp_valid,
	input  logic                 grp_stall,
	output pcct_pkg::out_item_t  grp
);

	logic                          busy_q;
	logic [pcct_pkg::ACC_W-1:0]    word_q;
	logic [pcct_pkg::CNT_W-1:0]    cnt_q;
	logic                          eol_q;
	logic                          out_valid_q;
	pcct_pkg::out_item_t           out_q;

	logic                          advance;
	logic                          has_grp;
	logic                          is_newline;
	logic [pcct_pkg::ACC_W-1:0]    grp_word;
	logic [pcct_pkg::GROUP_BITS-1:0] grp_val;
	logic [pcct_pkg::CNT_W-1:0]    nxt_cnt;
	logic                          done;
	logic                          emit;
	pcct_pkg::out_item_t           beat;

	assign advance = !out_valid_q || !grp_stall;

	// Next beat of the current job
	always_comb begin
		has_grp    = (cnt_q >= 4'd5);
		is_newline = (cnt_q == '0);
		grp_word   = word_q >> (cnt_q - 4'd5);
		if (has_grp) begin
			grp_val = grp_word[pcct_pkg::GROUP_BITS-1:0];
			nxt_cnt = cnt_q - 4'd5;
		end else begin
			// pad remainder with zeros on the right
			grp_val = 5'(word_q[pcct_pkg::GROUP_BITS-1:0] << (3'd5 - cnt_q[2:0]));
			nxt_cnt = '0;
		end
		if (is_newline) begin
			beat.out_char = pcct_pkg::NEWLINE_CHAR;
			beat.last     = 1'b1;
		end else begin
			beat.out_char = pcct_pkg::group_char(grp_val);
			beat.last     = 1'b0;
		end
		done  = is_newline || (!eol_q && nxt_cnt < 4'd5);
		emit  = busy_q && advance;
		q_pop = q_nonempty && (!busy_q || (emit && done));
	end

	// Job sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
		end else if (emit && done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			word_q <= q_head.word;
			cnt_q  <= q_head.cnt;
			eol_q  <= q_head.eol;
		end else if (emit) begin
			cnt_q <= nxt_cnt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= beat;
		end
	end

	assign grp_valid = out_valid_q;
	assign grp       = out_q;

endmodule

// ===== sv/pcct_checker.sv =====
// ----------------------------------------------------------------------------
// pcct_checker
// Port-level checks of the transcoder output channel.
// ----------------------------------------------------------------------------
module pcct_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                grp_valid,
	input logic                grp_stall,
	input pcct_pkg::out_item_t grp
);

	// A stalled beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		grp_valid && grp_stall |=> grp_valid && $stable(grp))
		else $error("output beat changed while stalled");

	// The closing beat is always a newline
	a_last_nl: assert property (@(posedge clk) disable iff (!arst_n)
		grp_valid && grp.last |-> grp.out_char == pcct_pkg::NEWLINE_CHAR)
		else $error("last beat is not a newline");

	// Group beats decode only to table characters
	a_grp_char: assert property (@(posedge clk) disable iff (!arst_n)
		grp_valid && !grp.last |->
			(grp.out_char >= 8'd65 && grp.out_char <= 8'd90) ||
			grp.out_char == 8'd32 || grp.out_char == 8'd46 ||
			grp.out_char == 8'd44 || grp.out_char == 8'd45 ||
			grp.out_char == 8'd39 || grp.out_char == 8'd63)
		else $error("group beat outside the character table");

endmodule

bind prefix_code_char_transcoder_core pcct_checker u_pcct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.grp_valid (grp_valid),
	.grp_stall (grp_stall),
	.grp       (grp)
);

// ===== verif/tb_prefix_code_char_transcoder_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_prefix_code_char_transcoder_core
// Self-checking bench for the prefix code transcoder. A short table of text
// beats covers flags, ignored bytes, empty and full remainders and the widest
// burst. Random lines of table characters mixed with noise follow, run under
// four idling phases. Result beats are checked against the beats typed in
// for fixed rows and against a bit-level encoder model kept in the bench.
// ----------------------------------------------------------------------------
module tb_prefix_code_char_transcoder_core;

	// Symbol set in group order, with the prefix code and length of each symbol
	localparam logic [0:31][7:0] SYM_TAB  = "ABCDEFGHIJKLMNOPQRSTUVWXYZ .,-'?";
	localparam logic [0:31][7:0] CODE_TAB = {
		8'h25, 8'h9A, 8'h05, 8'h01, 8'h06, 8'h09, 8'h9B, 8'h10, 8'h07, 8'h98, 8'h06,
		8'h04, 8'h99, 8'h9E, 8'h05, 8'h07, 8'h9F, 8'h08, 8'h06, 8'h07, 8'h9C, 8'h9D,
		8'h02, 8'h92, 8'h93, 8'h90, 8'h05, 8'h11, 8'h03, 8'h91, 8'h00, 8'h01};
	localparam logic [0:31][3:0] LEN_TAB  = {
		4'd6, 4'd8, 4'd4, 4'd4, 4'd3, 4'd5, 4'd8, 4'd6, 4'd4, 4'd8, 4'd4,
		4'd5, 4'd8, 4'd8, 4'd5, 4'd3, 4'd8, 4'd4, 4'd5, 4'd5, 4'd8, 4'd8,
		4'd6, 4'd8, 4'd8, 4'd8, 4'd3, 4'd6, 4'd6, 4'd8, 4'd6, 4'd6};

	localparam pcct_pkg::out_item_t NL_BEAT = '{out_char: pcct_pkg::NEWLINE_CHAR, last: 1'b1};
	localparam int PHASE_QUOTA = 75;

	// One text beat, with its result beats typed in where they are fixed
	typedef struct packed {
		pcct_pkg::in_item_t        stim;
		logic                      fixed;
		logic [2:0]                n_fixed;
		pcct_pkg::out_item_t [0:3] fixed_beats;
	} text_row_t;

	logic                clk;
	logic                arst_n;
	logic                chr_valid;
	logic                chr_stall;
	pcct_pkg::in_item_t  chr;
	logic                grp_valid;
	logic                grp_stall;
	pcct_pkg::out_item_t grp;

	// Encoder model state
	logic [11:0] pend_bits;
	int          pend_cnt;

	pcct_pkg::out_item_t pending_beats[$];
	text_row_t           text_rows[$];
	pcct_pkg::out_item_t got_beat;
	int                  err_cnt;
	int                  send_idle_pct;
	int                  rx_stall_pct;

	prefix_code_char_transcoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr       (chr),
		.grp_valid (grp_valid),
		.grp_stall (grp_stall),
		.grp       (grp)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic pcct_pkg::out_item_t chr_beat(input logic [7:0] c);
		return '{out_char: c, last: 1'b0};
	endfunction

	// Append the code bits of one beat, peel off full groups, flush at end of line.
	// With keep clear only the state moves (the beats are typed in by the caller).
	task automatic encode_beat(input pcct_pkg::in_item_t it, input bit keep);
		int          i;
		bit          hit;
		logic [4:0]  g;
		logic [11:0] padded;
		hit = 1'b0;
		if (it.char_valid) begin
			for (i = 0; i < 32; i++) begin
				if (!hit && SYM_TAB[i] == it.in_char) begin
					hit = 1'b1;
					pend_bits = (pend_bits << LEN_TAB[i]) | {4'd0, CODE_TAB[i]};
					pend_cnt += LEN_TAB[i];
				end
			end
			while (pend_cnt >= 5) begin
				g = pend_bits[pend_cnt-1 -: 5];
				if (keep)
					pending_beats.push_back(chr_beat(SYM_TAB[g]));
				pend_cnt -= 5;
				pend_bits = pend_bits & ((12'd1 << pend_cnt) - 12'd1);
			end
		end
		if (it.end_of_line) begin
			// remainder padded with zeros on the right; nothing when empty
			if (pend_cnt > 0) begin
				padded = pend_bits << (5 - pend_cnt);
				g = padded[4:0];
				if (keep)
					pending_beats.push_back(chr_beat(SYM_TAB[g]));
			end
			if (keep)
				pending_beats.push_back(NL_BEAT);
			pend_bits = '0;
			pend_cnt = 0;
		end
	endtask

	// n < 0: results come from the model
	task automatic add_row(input logic [7:0] ch, input logic v, input logic e, input int n,
			input pcct_pkg::out_item_t b0, input pcct_pkg::out_item_t b1,
			input pcct_pkg::out_item_t b2);
		text_row_t row;
		row.stim = '{in_char: ch, char_valid: v, end_of_line: e};
		row.fixed = (n >= 0);
		row.n_fixed = (n >= 0) ? n[2:0] : 3'd0;
		row.fixed_beats = {b0, b1, b2, NL_BEAT};
		text_rows.push_back(row);
	endtask

	// Drive one beat, with random idle cycles ahead of it; returns at the accepting edge
	task automatic send_row(input text_row_t row);
		int k;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			chr_valid <= 1'b0;
			@(posedge clk);
		end
		chr <= row.stim;
		chr_valid <= 1'b1;
		@(posedge clk);
		while (chr_stall)
			@(posedge clk);
		encode_beat(row.stim, !row.fixed);
		if (row.fixed)
			for (k = 0; k < row.n_fixed; k++)
				pending_beats.push_back(row.fixed_beats[k]);
	endtask

	// Random lines: mostly table characters, some noise, half closed by a bare end of line
	task automatic send_random_text(input int quota);
		int        sent;
		int        n;
		int        k;
		int        pick;
		text_row_t row;
		sent = 0;
		row = '0;
		while (sent < quota) begin
			n = $urandom_range(0, 9);
			for (k = 0; k <= n; k++) begin
				pick = $urandom_range(0, 99);
				row.stim.end_of_line = (k == n);
				if (pick < 85) begin
					row.stim.in_char = SYM_TAB[$urandom_range(0, 31)];
					row.stim.char_valid = 1'b1;
				end else begin
					row.stim.in_char = 8'($urandom_range(0, 255));
					row.stim.char_valid = 1'($urandom_range(0, 1));
				end
				if (k == n && $urandom_range(0, 1))
					row.stim.char_valid = 1'b0;
				sent++;
				send_row(row);
			end
		end
	endtask

	// Receiver stall
	initial begin
		grp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			grp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
		end
	end

	// Result check
	always @(posedge clk) begin
		if (arst_n && grp_valid && !grp_stall) begin
			if (pending_beats.size() == 0) begin
				report_mismatch($sformatf("beat 0x%02h last %0b with nothing expected",
					grp.out_char, grp.last));
			end else begin
				got_beat = pending_beats.pop_front();
				if (grp.out_char !== got_beat.out_char)
					report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
						grp.out_char, got_beat.out_char));
				if (grp.last !== got_beat.last)
					report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
						grp.last, got_beat.last, got_beat.out_char));
			end
		end
	end

	// Run limit
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	// Main sequence
	initial begin
		arst_n <= 1'b0;
		chr_valid <= 1'b0;
		chr <= '0;
		pend_bits = '0;
		pend_cnt = 0;
		err_cnt = 0;
		send_idle_pct = 0;
		rx_stall_pct = 0;

		// bare end of line, flags off, bytes outside the table
		add_row(8'h00, 1'b0, 1'b1, 1, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row("A", 1'b0, 1'b0, 0, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row(8'h00, 1'b1, 1'b0, 0, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row(8'hFF, 1'b1, 1'b1, 1, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row("a", 1'b1, 1'b1, 1, NL_BEAT, NL_BEAT, NL_BEAT);
		// char and flush together: short pad, empty remainder, split code
		add_row("E", 1'b1, 1'b1, 2, chr_beat("Y"), NL_BEAT, NL_BEAT);
		add_row("F", 1'b1, 1'b1, 2, chr_beat("J"), NL_BEAT, NL_BEAT);
		add_row("B", 1'b1, 1'b1, 3, chr_beat("T"), chr_beat("I"), NL_BEAT);
		add_row("P", 1'b1, 1'b1, 2, chr_beat(","), NL_BEAT, NL_BEAT);
		// four bits pending, then an 8-bit code with flush: four beats
		add_row("C", 1'b1, 1'b0, -1, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row("Z", 1'b1, 1'b1, -1, NL_BEAT, NL_BEAT, NL_BEAT);
		// punctuation, then ignored beats mid line and a flush
		add_row(" ", 1'b1, 1'b0, -1, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row(".", 1'b1, 1'b0, -1, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row(",", 1'b1, 1'b0, -1, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row("-", 1'b1, 1'b0, -1, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row(8'd39, 1'b1, 1'b0, -1, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row("?", 1'b1, 1'b0, -1, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row("Q", 1'b1, 1'b0, -1, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row("E", 1'b0, 1'b0, -1, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row(8'h80, 1'b1, 1'b0, -1, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row("X", 1'b0, 1'b1, -1, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row("D", 1'b1, 1'b0, -1, NL_BEAT, NL_BEAT, NL_BEAT);
		add_row(8'h7F, 1'b1, 1'b1, -1, NL_BEAT, NL_BEAT, NL_BEAT);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (text_rows[i])
			send_row(text_rows[i]);

		// random text under each idling phase
		send_random_text(PHASE_QUOTA);
		send_idle_pct = 51;
		send_random_text(PHASE_QUOTA);
		send_idle_pct = 0;
		rx_stall_pct = 51;
		send_random_text(PHASE_QUOTA);
		send_idle_pct = 9;
		rx_stall_pct = 9;
		send_random_text(PHASE_QUOTA);
		chr_valid <= 1'b0;

		// drain, then watch for stray beats
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== prefix_code_char_transcoder_core.f =====
sv/pcct_pkg.sv
sv/pcct_front.sv
sv/pcct_queue.sv
sv/pcct_back.sv
sv/prefix_code_char_transcoder_core.sv
sv/pcct_checker.sv
verif/tb_prefix_code_char_transcoder_core.sv
